// File: rtl/fifo_ready_queue_dispatcher_core_macros.svh
// Assertion macros shared by the ready queue dispatcher RTL.
`ifndef FIFO_READY_QUEUE_DISPATCHER_CORE_MACROS_SVH
`define FIFO_READY_QUEUE_DISPATCHER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FRQD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("frqd check failed");

// Next-cycle implication, disabled while reset is asserted.
`define FRQD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("frqd check failed");

`endif

// File: rtl/frqd_pkg.sv
// Package with constants, codes and payload types of the ready queue dispatcher.
package frqd_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int PID_BITS = 8;
	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int PID_COUNT = 1 << PID_BITS;
	localparam logic [15:0] QUANTUM_RESET = 16'd100;

	typedef enum logic {
		KIND_INSERT = 1'b0,
		KIND_DISPATCH = 1'b1
	} kind_t;

	typedef enum logic [2:0] {
		OUT_INSERTED = 3'd0,
		OUT_DUPLICATE = 3'd1,
		OUT_FULL = 3'd2,
		OUT_DISPATCHED = 3'd3,
		OUT_IDLE = 3'd4
	} outcome_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK,
		ST_POP
	} state_t;

	typedef struct packed {
		logic kind;
		logic [7:0] proc_id;
		logic current_running;
		logic [31:0] now_time;
	} req_t;

	typedef struct packed {
		logic [2:0] outcome;
		logic [7:0] chosen_pid;
		logic [15:0] timer_load;
		logic [31:0] dispatch_time;
	} rsp_t;

endpackage

// File: rtl/fifo_ready_queue_dispatcher_core.sv
// Round-robin ready queue of process ids with dispatch to a current process.
//
// Channels: in_valid/in_ready carry one request (insert a pid, or dispatch
// the next process); out_valid/out_ready return exactly one response per
// request; cfg_valid/cfg_ready write the 16-bit time quantum (reset 100).
// The user must write the quantum only while no request is in flight; the
// block itself does not enforce this. An insert passes the states IDLE and
// LOOK, a dispatch IDLE, LOOK and POP; no new request is taken before the
// response is registered. The accept cycle reads the presence memory, the
// next decides and writes the queue memory (requeue at the tail, read at the
// head), and a dispatch spends the POP state on the registered read data of the queue.
// Both the queue (16 entries) and the presence bitmap (256 entries) are
// synchronous memories with registered read data.
// Reset: the queue is empty and no process is current; a clearing pass then
// zeroes all 256 entries of the presence memory, and requests are accepted
// from the cycle after it ends.
// Stall: a response holds in the output register while out_ready is low;
// a new request is taken in the same cycle the held response leaves.
`include "fifo_ready_queue_dispatcher_core_macros.svh"

module fifo_ready_queue_dispatcher_core (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  frqd_pkg::req_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output frqd_pkg::rsp_t out_data,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [15:0] cfg_data
);
	import frqd_pkg::*;

	state_t state_q, state_d;

	logic [15:0] quantum_q;
	logic [IDX_W-1:0] head_q, tail_q;
	logic [CNT_W-1:0] count_q, count_after, count_d;
	logic [PID_BITS-1:0] cur_pid_q;
	logic cur_valid_q;
	logic [PID_BITS-1:0] clr_q;

	logic [PID_BITS-1:0] mem_q [QUEUE_DEPTH];
	logic [PID_BITS-1:0] rdata_q;
	logic pres_q [PID_COUNT];
	logic pres_rd_q;

	logic ins_s1, try_s1, pop_s1, fwd_s1;
	logic [PID_BITS-1:0] pid_s1;
	logic [31:0] now_s1;

	logic out_valid_q;
	rsp_t out_data_q;

	logic acc, is_ins, enq_try, look, full, enq_do, pop_do, fwd;
	logic [PID_BITS-1:0] enq_pid, pop_pid;
	logic pres_we, pres_wd;
	logic [PID_BITS-1:0] pres_wa;
	logic load_ins, load_pop, clr_last;
	outcome_t ins_outcome;

	function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] idx);
		logic [IDX_W-1:0] r;
		r = (idx == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : idx + IDX_W'(1);
		return r;
	endfunction

	// Accept cycle picks the pid to look up; the lookup cycle decides the enqueue.
	always_comb begin
		acc = in_valid & in_ready;
		is_ins = (in_data.kind == KIND_INSERT);
		if (is_ins) begin
			enq_pid = in_data.proc_id[PID_BITS-1:0];
			enq_try = 1'b1;
		end else begin
			enq_pid = cur_pid_q;
			enq_try = cur_valid_q & in_data.current_running;
		end
		look = (state_q == ST_LOOK);
		full = (count_q == CNT_W'(QUEUE_DEPTH));
		enq_do = look & try_s1 & ~pres_rd_q & ~full;
		count_after = count_q + CNT_W'(enq_do);
		pop_do = look & ~ins_s1 & (count_after != '0);
		// requeue into an empty queue: the popped entry is the one just written
		fwd = enq_do & (count_q == '0);
		count_d = count_after - CNT_W'(pop_do);
		if (pres_rd_q) begin
			ins_outcome = OUT_DUPLICATE;
		end else if (full) begin
			ins_outcome = OUT_FULL;
		end else begin
			ins_outcome = OUT_INSERTED;
		end
		load_ins = look & ins_s1;
		load_pop = (state_q == ST_POP);
		pop_pid = fwd_s1 ? cur_pid_q : rdata_q;
		clr_last = (clr_q == PID_BITS'(PID_COUNT - 1));
		// one write port on the presence memory: clear pass, set on enqueue, drop on pop
		pres_we = 1'b0;
		pres_wa = clr_q;
		pres_wd = 1'b0;
		if (state_q == ST_CLEAR) begin
			pres_we = 1'b1;
		end else if (enq_do) begin
			pres_we = 1'b1;
			pres_wa = pid_s1;
			pres_wd = 1'b1;
		end else if (load_pop && pop_s1) begin
			pres_we = 1'b1;
			pres_wa = pop_pid;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (acc) state_d = ST_LOOK;
			end
			ST_LOOK: begin
				state_d = ins_s1 ? ST_IDLE : ST_POP;
			end
			ST_POP: begin
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Handshake outputs.
	always_comb begin
		unique case (state_q)
			ST_IDLE: in_ready = !out_valid_q || out_ready;
			ST_CLEAR, ST_LOOK, ST_POP: in_ready = 1'b0;
			default: in_ready = 1'b0;
		endcase
		cfg_ready = 1'b1;
		out_valid = out_valid_q;
		out_data = out_data_q;
	end

	// Queue memory: write at tail, read at head, registered read data.
	always_ff @(posedge clk) begin
		if (enq_do) mem_q[tail_q] <= pid_s1;
		if (pop_do) rdata_q <= mem_q[head_q];
	end

	// Presence memory: one write port, registered read data.
	always_ff @(posedge clk) begin
		if (pres_we) pres_q[pres_wa] <= pres_wd;
		if (acc) pres_rd_q <= pres_q[enq_pid];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			quantum_q <= QUANTUM_RESET;
			head_q <= '0;
			tail_q <= '0;
			count_q <= '0;
			cur_pid_q <= '0;
			cur_valid_q <= 1'b0;
			ins_s1 <= 1'b0;
			try_s1 <= 1'b0;
			pid_s1 <= '0;
			pop_s1 <= 1'b0;
			fwd_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + PID_BITS'(1);
			if (cfg_valid && cfg_ready) quantum_q <= cfg_data;
			if (acc) begin
				ins_s1 <= is_ins;
				try_s1 <= enq_try;
				pid_s1 <= enq_pid;
			end
			if (look) begin
				count_q <= count_d;
				pop_s1 <= pop_do;
				fwd_s1 <= fwd;
			end
			if (enq_do) tail_q <= next_slot(tail_q);
			if (pop_do) head_q <= next_slot(head_q);
			if (load_pop) begin
				if (pop_s1) begin
					cur_pid_q <= pop_pid;
					cur_valid_q <= 1'b1;
				end else begin
					cur_pid_q <= '0;
					cur_valid_q <= 1'b0;
				end
			end
			if (load_ins || load_pop) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (acc) now_s1 <= in_data.now_time;
		if (load_ins) begin
			out_data_q.outcome <= ins_outcome;
			out_data_q.chosen_pid <= '0;
			out_data_q.timer_load <= '0;
			out_data_q.dispatch_time <= '0;
		end else if (load_pop) begin
			if (pop_s1) begin
				out_data_q.outcome <= OUT_DISPATCHED;
				out_data_q.chosen_pid <= 8'(pop_pid);
				out_data_q.timer_load <= quantum_q;
				out_data_q.dispatch_time <= now_s1;
			end else begin
				out_data_q.outcome <= OUT_IDLE;
				out_data_q.chosen_pid <= '0;
				out_data_q.timer_load <= '0;
				out_data_q.dispatch_time <= '0;
			end
		end
	end

	`FRQD_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(QUEUE_DEPTH))
	`FRQD_ASSERT_NOW(a_busy_out_free, clk, arst_n, state_q != ST_IDLE, !out_valid_q)
	`FRQD_ASSERT_NEXT(a_pop_one_cycle, clk, arst_n, state_q == ST_POP, state_q == ST_IDLE)
	`FRQD_ASSERT_NEXT(a_accept_to_look, clk, arst_n, acc, state_q == ST_LOOK)

endmodule
